### design/ray_box_exit_vector_unit_defines.svh
// Assertion macros shared by the ray box exit vector checker.
`ifndef RAY_BOX_EXIT_VECTOR_UNIT_DEFINES_SVH
`define RAY_BOX_EXIT_VECTOR_UNIT_DEFINES_SVH

// Clocked assertion, switched off while reset is held.
`define RBEV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that also covers the reset cycles.
`define RBEV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### design/rbev_pkg.sv
// Shared constants and register codes for the ray box exit vector unit.
package rbev_pkg;

    localparam int NUM_AXES   = 3;
    localparam int NUM_PLANES = 6;
    localparam int CFG_ADDR_W = 3;

    // Reset values of the box bounds, 1/64 cm.
    localparam int RST_X_MIN = 0;
    localparam int RST_X_MAX = 16384;
    localparam int RST_Y_MIN = -7456;
    localparam int RST_Y_MAX = 7456;
    localparam int RST_Z_MIN = 0;
    localparam int RST_Z_MAX = 66368;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_X_MIN = 3'd0,
        REG_X_MAX = 3'd1,
        REG_Y_MIN = 3'd2,
        REG_Y_MAX = 3'd3,
        REG_Z_MIN = 3'd4,
        REG_Z_MAX = 3'd5
    } cfg_reg_t;

endpackage

### design/ray_box_exit_vector_unit.sv
// Top level of the ray box exit vector unit.
// Takes one ray per cycle while the output is not stalled and returns the vector
// from the ray start to where it leaves the configured box, with a found flag in
// m_tuser. Most of the pipeline is the off-axis dividers, resolving one quotient bit
// per pipeline stage, followed by the six-way compare tree. The whole pipeline
// advances together and halts while a result word waits at the output. Box bounds
// must be written through the cfg port only while no ray is in flight; not enforced.
module ray_box_exit_vector_unit import rbev_pkg::*; #(
    parameter int COORD_BITS = 24,
    parameter int DIR_BITS   = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // start_x, start_y, start_z, dir_x, dir_y, dir_z
    input  logic [((3*COORD_BITS+3*DIR_BITS+7)/8)*8-1:0] s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // delta_x, delta_y, delta_z
    output logic [((3*COORD_BITS+3+7)/8)*8-1:0] m_tdata,
    // exit_found
    output logic                    m_tuser,
    input  logic                    cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [COORD_BITS-1:0]   cfg_wr_data
);

    localparam int OUT_TW   = ((3*COORD_BITS+3+7)/8)*8;
    localparam int LAT_CAND = COORD_BITS + 5;
    localparam int LAT      = LAT_CAND + 6;

    logic signed [COORD_BITS-1:0] box_lo_reg [0:NUM_AXES-1];
    logic signed [COORD_BITS-1:0] box_hi_reg [0:NUM_AXES-1];
    logic                         vld_reg    [0:LAT-1];
    logic                         en;

    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_lo_reg[0] <= COORD_BITS'(RST_X_MIN);
            box_hi_reg[0] <= COORD_BITS'(RST_X_MAX);
            box_lo_reg[1] <= COORD_BITS'(RST_Y_MIN);
            box_hi_reg[1] <= COORD_BITS'(RST_Y_MAX);
            box_lo_reg[2] <= COORD_BITS'(RST_Z_MIN);
            box_hi_reg[2] <= COORD_BITS'(RST_Z_MAX);
            for (int k = 0; k < LAT; k++) vld_reg[k] <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_addr))
                    REG_X_MIN: box_lo_reg[0] <= cfg_wr_data;
                    REG_X_MAX: box_hi_reg[0] <= cfg_wr_data;
                    REG_Y_MIN: box_lo_reg[1] <= cfg_wr_data;
                    REG_Y_MAX: box_hi_reg[1] <= cfg_wr_data;
                    REG_Z_MIN: box_lo_reg[2] <= cfg_wr_data;
                    REG_Z_MAX: box_hi_reg[2] <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (en) begin
                vld_reg[0] <= s_tvalid;
                for (int k = 1; k < LAT; k++) vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    logic signed [COORD_BITS-1:0] start [0:NUM_AXES-1];
    logic signed [DIR_BITS-1:0]   dir   [0:NUM_AXES-1];

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            start[a] = s_tdata[a*COORD_BITS +: COORD_BITS];
            dir[a]   = s_tdata[NUM_AXES*COORD_BITS + a*DIR_BITS +: DIR_BITS];
        end
    end

    // start point kept alongside the candidate pipeline for the no-exit case
    logic signed [COORD_BITS-1:0] start_dly_reg [0:LAT_CAND-1][0:NUM_AXES-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            start_dly_reg[0] <= start;
            for (int k = 1; k < LAT_CAND; k++) start_dly_reg[k] <= start_dly_reg[k-1];
        end
    end

    logic                     c_ok    [0:NUM_PLANES-1];
    logic [COORD_BITS:0]      c_n     [0:NUM_PLANES-1];
    logic [DIR_BITS-1:0]      c_dm    [0:NUM_PLANES-1];
    logic signed [COORD_BITS:0] c_delta [0:NUM_PLANES-1][0:NUM_AXES-1];

    for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
        rbev_cand #(.CW(COORD_BITS), .DW(DIR_BITS), .AXIS(p/2)) u_cand (
            .aclk       (aclk),
            .en         (en),
            .plane      ((p % 2) != 0 ? box_hi_reg[p/2] : box_lo_reg[p/2]),
            .start      (start),
            .dir        (dir),
            .box_lo     (box_lo_reg),
            .box_hi     (box_hi_reg),
            .cand_ok    (c_ok[p]),
            .cand_n     (c_n[p]),
            .cand_dm    (c_dm[p]),
            .cand_delta (c_delta[p])
        );
    end

    logic                       found;
    logic signed [COORD_BITS:0] delta [0:NUM_AXES-1];

    rbev_select #(.CW(COORD_BITS), .DW(DIR_BITS)) u_select (
        .aclk       (aclk),
        .en         (en),
        .cand_ok    (c_ok),
        .cand_n     (c_n),
        .cand_dm    (c_dm),
        .cand_delta (c_delta),
        .start      (start_dly_reg[LAT_CAND-1]),
        .found      (found),
        .delta      (delta)
    );

    assign m_tdata = OUT_TW'({delta[2], delta[1], delta[0]});
    assign m_tuser = found;

endmodule

### design/rbev_divpipe.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module rbev_divpipe #(
    parameter int QW = 25,
    parameter int DW = 16
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [QW+DW-1:0]     dividend,
    input  logic [DW-1:0]        divisor,
    output logic [QW-1:0]        quotient,
    output logic                 overflow
);

    logic [DW-1:0] rem_reg [0:QW-1];
    logic [QW-1:0] low_reg [0:QW-1];
    logic [DW-1:0] dvs_reg [0:QW-1];
    logic [QW-1:0] quo_reg [0:QW];
    logic          ovf_reg [0:QW];

    logic [DW:0]   trial   [0:QW-1];
    logic          ge      [0:QW-1];
    logic [DW-1:0] rem_nx  [0:QW-2];

    always_comb begin
        for (int k = 0; k < QW; k++) begin
            trial[k] = {rem_reg[k], low_reg[k][QW-1]};
            ge[k]    = trial[k] >= {1'b0, dvs_reg[k]};
        end
        for (int k = 0; k < QW - 1; k++) begin
            rem_nx[k] = ge[k] ? DW'(trial[k] - {1'b0, dvs_reg[k]}) : trial[k][DW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // quotient would not fit in QW bits
            ovf_reg[0] <= dividend[QW+DW-1:QW] >= divisor;
            rem_reg[0] <= dividend[QW+DW-1:QW];
            low_reg[0] <= dividend[QW-1:0];
            dvs_reg[0] <= divisor;
            quo_reg[0] <= '0;
            for (int k = 1; k < QW; k++) begin
                rem_reg[k] <= rem_nx[k-1];
                low_reg[k] <= {low_reg[k-1][QW-2:0], 1'b0};
                dvs_reg[k] <= dvs_reg[k-1];
            end
            for (int k = 1; k <= QW; k++) begin
                quo_reg[k] <= {quo_reg[k-1][QW-2:0], ge[k-1]};
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign quotient = quo_reg[QW];
    assign overflow = ovf_reg[QW];

endmodule

### design/rbev_cand.sv
// Candidate exit point on one box plane: slab offset, two divisions, inside test.
module rbev_cand import rbev_pkg::*; #(
    parameter int CW   = 24,
    parameter int DW   = 16,
    parameter int AXIS = 0
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [CW-1:0] plane,
    input  logic signed [CW-1:0] start   [0:NUM_AXES-1],
    input  logic signed [DW-1:0] dir     [0:NUM_AXES-1],
    input  logic signed [CW-1:0] box_lo  [0:NUM_AXES-1],
    input  logic signed [CW-1:0] box_hi  [0:NUM_AXES-1],
    output logic                 cand_ok,
    output logic [CW:0]          cand_n,
    output logic [DW-1:0]        cand_dm,
    output logic signed [CW:0]   cand_delta [0:NUM_AXES-1]
);

    localparam int QW = CW + 1;
    localparam int B1 = (AXIS + 1) % NUM_AXES;
    localparam int B2 = (AXIS + 2) % NUM_AXES;

    typedef struct packed {
        logic                 ok;
        logic [CW:0]          n;
        logic [DW-1:0]        dm;
        logic signed [CW:0]   num;
        logic                 neg1;
        logic                 neg2;
        logic signed [CW-1:0] s1;
        logic signed [CW-1:0] s2;
    } side_t;

    side_t             side_next;
    side_t             side_a_reg, side_b_reg;
    side_t             side_d_reg [0:QW];
    logic [DW-1:0]     db1_reg, db2_reg;
    logic [QW+DW-1:0]  prod1_reg, prod2_reg;

    logic signed [CW:0] num;
    logic               num_neg, da_neg;

    always_comb begin
        num     = $signed({plane[CW-1], plane}) - $signed({start[AXIS][CW-1], start[AXIS]});
        num_neg = num[CW];
        da_neg  = dir[AXIS][DW-1];
        side_next.num  = num;
        side_next.n    = num_neg ? (CW+1)'(-num) : num;
        side_next.dm   = da_neg ? DW'(-dir[AXIS]) : dir[AXIS];
        // ray must head towards the plane, or start on it
        side_next.ok   = (dir[AXIS] != '0) && ((num == '0) || (num_neg == da_neg));
        side_next.neg1 = num_neg ^ dir[B1][DW-1] ^ da_neg;
        side_next.neg2 = num_neg ^ dir[B2][DW-1] ^ da_neg;
        side_next.s1   = start[B1];
        side_next.s2   = start[B2];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_a_reg <= side_next;
            db1_reg    <= dir[B1][DW-1] ? DW'(-dir[B1]) : dir[B1];
            db2_reg    <= dir[B2][DW-1] ? DW'(-dir[B2]) : dir[B2];
            side_b_reg <= side_a_reg;
            prod1_reg  <= side_a_reg.n * db1_reg;
            prod2_reg  <= side_a_reg.n * db2_reg;
            side_d_reg[0] <= side_b_reg;
            for (int k = 1; k <= QW; k++) begin
                side_d_reg[k] <= side_d_reg[k-1];
            end
        end
    end

    logic [QW-1:0] q1, q2;
    logic          ovf1, ovf2;

    rbev_divpipe #(.QW(QW), .DW(DW)) u_div1 (
        .aclk     (aclk),
        .en       (en),
        .dividend (prod1_reg),
        .divisor  (side_b_reg.dm),
        .quotient (q1),
        .overflow (ovf1)
    );

    rbev_divpipe #(.QW(QW), .DW(DW)) u_div2 (
        .aclk     (aclk),
        .en       (en),
        .dividend (prod2_reg),
        .divisor  (side_b_reg.dm),
        .quotient (q2),
        .overflow (ovf2)
    );

    side_t                sd;
    logic signed [CW+1:0] off1, off2;
    logic signed [CW+2:0] pt1, pt2;
    logic                 in1, in2, in_a, ok_next;

    always_comb begin
        sd   = side_d_reg[QW];
        off1 = $signed({1'b0, q1});
        off2 = $signed({1'b0, q2});
        if (sd.neg1) off1 = -off1;
        if (sd.neg2) off2 = -off2;
        pt1 = $signed({{3{sd.s1[CW-1]}}, sd.s1}) + $signed({off1[CW+1], off1});
        pt2 = $signed({{3{sd.s2[CW-1]}}, sd.s2}) + $signed({off2[CW+1], off2});
        in1 = !ovf1 && (pt1 >= $signed({{3{box_lo[B1][CW-1]}}, box_lo[B1]}))
                    && (pt1 <= $signed({{3{box_hi[B1][CW-1]}}, box_hi[B1]}));
        in2 = !ovf2 && (pt2 >= $signed({{3{box_lo[B2][CW-1]}}, box_lo[B2]}))
                    && (pt2 <= $signed({{3{box_hi[B2][CW-1]}}, box_hi[B2]}));
        in_a = (plane >= box_lo[AXIS]) && (plane <= box_hi[AXIS]);
        ok_next = sd.ok && in1 && in2 && in_a;
    end

    logic               ok_reg;
    logic [CW:0]        n_reg;
    logic [DW-1:0]      dm_reg;
    logic signed [CW:0] da_reg, d1_reg, d2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ok_reg <= ok_next;
            n_reg  <= sd.n;
            dm_reg <= sd.dm;
            da_reg <= sd.num;
            d1_reg <= off1[CW:0];
            d2_reg <= off2[CW:0];
        end
    end

    always_comb begin
        cand_ok          = ok_reg;
        cand_n           = n_reg;
        cand_dm          = dm_reg;
        cand_delta[AXIS] = da_reg;
        cand_delta[B1]   = d1_reg;
        cand_delta[B2]   = d2_reg;
    end

endmodule

### design/rbev_select.sv
// Registered compare tree picking the nearest forward candidate, earlier plane on ties.
module rbev_select import rbev_pkg::*; #(
    parameter int CW = 24,
    parameter int DW = 16
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic                 cand_ok    [0:NUM_PLANES-1],
    input  logic [CW:0]          cand_n     [0:NUM_PLANES-1],
    input  logic [DW-1:0]        cand_dm    [0:NUM_PLANES-1],
    input  logic signed [CW:0]   cand_delta [0:NUM_PLANES-1][0:NUM_AXES-1],
    input  logic signed [CW-1:0] start      [0:NUM_AXES-1],
    output logic                 found,
    output logic signed [CW:0]   delta      [0:NUM_AXES-1]
);

    typedef struct packed {
        logic                          ok;
        logic [CW:0]                   n;
        logic [DW-1:0]                 dm;
        logic [NUM_AXES-1:0][CW:0]     delta;
    } cand_t;

    typedef logic [CW+DW:0] prod_t;

    // right side wins only when strictly nearer
    function automatic cand_t pick(cand_t l, cand_t r, prod_t x, prod_t y);
        pick = (r.ok && (!l.ok || (y < x))) ? r : l;
    endfunction

    cand_t cin [0:NUM_PLANES-1];

    always_comb begin
        for (int i = 0; i < NUM_PLANES; i++) begin
            cin[i].ok = cand_ok[i];
            cin[i].n  = cand_n[i];
            cin[i].dm = cand_dm[i];
            for (int b = 0; b < NUM_AXES; b++) begin
                cin[i].delta[b] = cand_delta[i][b];
            end
        end
    end

    cand_t c1_reg [0:NUM_PLANES-1];
    prod_t x1_reg [0:2];
    prod_t y1_reg [0:2];
    cand_t w1_reg [0:2];
    cand_t a2_reg, b2_reg, c2_reg, u_reg, c3_reg, a4_reg, b4_reg;
    prod_t x2_reg, y2_reg, x4_reg, y4_reg;
    logic signed [CW-1:0] sd_reg [0:4][0:NUM_AXES-1];
    cand_t fin;
    logic                 found_reg;
    logic signed [CW:0]   delta_reg [0:NUM_AXES-1];

    assign fin = pick(a4_reg, b4_reg, x4_reg, y4_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NUM_PLANES; i++) c1_reg[i] <= cin[i];
            for (int j = 0; j < 3; j++) begin
                x1_reg[j] <= cin[2*j].n * cin[2*j+1].dm;
                y1_reg[j] <= cin[2*j+1].n * cin[2*j].dm;
                w1_reg[j] <= pick(c1_reg[2*j], c1_reg[2*j+1], x1_reg[j], y1_reg[j]);
            end
            a2_reg <= w1_reg[0];
            b2_reg <= w1_reg[1];
            c2_reg <= w1_reg[2];
            x2_reg <= w1_reg[0].n * w1_reg[1].dm;
            y2_reg <= w1_reg[1].n * w1_reg[0].dm;
            u_reg  <= pick(a2_reg, b2_reg, x2_reg, y2_reg);
            c3_reg <= c2_reg;
            a4_reg <= u_reg;
            b4_reg <= c3_reg;
            x4_reg <= u_reg.n * c3_reg.dm;
            y4_reg <= c3_reg.n * u_reg.dm;
            sd_reg[0] <= start;
            for (int k = 1; k < 5; k++) sd_reg[k] <= sd_reg[k-1];
            found_reg <= fin.ok;
            for (int b = 0; b < NUM_AXES; b++) begin
                // no exit: vector back to the origin
                delta_reg[b] <= fin.ok ? $signed(fin.delta[b])
                                       : -$signed({sd_reg[4][b][CW-1], sd_reg[4][b]});
            end
        end
    end

    assign found = found_reg;
    assign delta = delta_reg;

endmodule

### design/rbev_checker.sv
// Port-level checker for the ray box exit vector unit, bound to the top level.
`include "ray_box_exit_vector_unit_defines.svh"

module rbev_checker #(
    parameter int COORD_BITS = 24,
    parameter int DIR_BITS   = 16
) (
    input logic                                       aclk,
    input logic                                       aresetn,
    input logic                                       s_tready,
    input logic                                       m_tvalid,
    input logic                                       m_tready,
    input logic [((3*COORD_BITS+3+7)/8)*8-1:0]        m_tdata,
    input logic                                       m_tuser
);

    // output goes quiet straight after reset
    `RBEV_ASSERT_ALWAYS(a_rst_idle, !aresetn |=> !m_tvalid, "result valid after reset")
    `RBEV_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result word changed")
    // whole pipeline halts while a result word waits
    `RBEV_ASSERT(a_stall, m_tvalid && !m_tready |-> !s_tready, "input taken while output stalled")
    `RBEV_ASSERT(a_free, !m_tvalid |-> s_tready, "input refused with empty output")

endmodule

bind ray_box_exit_vector_unit rbev_checker #(
    .COORD_BITS (COORD_BITS),
    .DIR_BITS   (DIR_BITS)
) u_rbev_checker (.*);
